// ===== hw/rtl/salc_pkg.sv =====
// Shared types and constants for the set-associative LRU cache tag core
`timescale 1ns / 1ps
`default_nettype none
package salc_pkg;
    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS = 8;
    localparam int ADDR_WIDTH = 64;
    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int WAY_W = $clog2(MAX_WAYS);
    localparam int FILL_W = $clog2(MAX_WAYS + 1);
    localparam int SET_W = MAX_SET_BITS;
    localparam int TAG_W = ADDR_WIDTH;
    localparam int CNT_W = 32;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_STORE = 2'd1;
    localparam logic [1:0] CMD_MODIFY = 2'd2;
    localparam logic [1:0] CMD_IFETCH = 2'd3;

    localparam logic [1:0] REG_SET_BITS = 2'd0;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic load;
        logic read;
        logic update;
        logic last;
    } ctl_t;

    typedef struct packed {
        logic modify;
        logic skip;
    } sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/set_assoc_lru_cache_tags_core.sv =====
// Top level of the set-associative LRU cache tag core
//  channel | signals                               | handshake
//  input   | cmd, address                          | start & !busy
//  result  | hit miss evict last *_count            | strobe, one cycle
//  config  | cfg_we, cfg_index, cfg_data           | cfg_we
// Each access is a set row read, then an update; a load or store holds
// busy through the read and update pair, a modify repeats the pair, a fetch is dropped at once.
// The result appears the cycle after the update. Reset clears the per-set
// used flags and totals at once; an unused set holds no valid lines.
// The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_lru_cache_tags_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [63:0] address,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [5:0]  cfg_data,
    output logic             strobe,
    output logic             hit,
    output logic             miss,
    output logic             evict,
    output logic             last,
    output logic [31:0]      hit_count,
    output logic [31:0]      miss_count,
    output logic [31:0]      evict_count
);
    salc_pkg::ctl_t ctl;
    salc_pkg::sts_t sts;

    salc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .ctl(ctl), .busy(busy)
    );

    salc_dp u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd(cmd), .address(address), .strobe(strobe),
        .hit(hit), .miss(miss), .evict(evict), .last(last),
        .hit_count(hit_count), .miss_count(miss_count), .evict_count(evict_count)
    );

    a_onehot_res: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (hit ^ miss)) else $error("hit and miss not exclusive");
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && evict |-> miss) else $error("evict without miss");
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.update |=> strobe) else $error("result lost");
endmodule
`default_nettype wire

// ===== hw/rtl/salc_ctrl.sv =====
// Sequencer that runs each access as a read and update pair; a modify repeats the pair
`timescale 1ns / 1ps
`default_nettype none
module salc_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire salc_pkg::sts_t  sts,
    output salc_pkg::ctl_t       ctl,
    output logic                 busy
);
    salc_pkg::state_t state_reg, state_next;
    logic second_reg, second_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= salc_pkg::ST_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            second_reg <= second_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        second_next = second_reg;
        unique case (state_reg)
            salc_pkg::ST_IDLE:
            begin
                second_next = 1'b0;
                if (start && !sts.skip)
                    state_next = salc_pkg::ST_READ;
            end
            salc_pkg::ST_READ:
                state_next = salc_pkg::ST_UPDATE;
            salc_pkg::ST_UPDATE:
            begin
                if (sts.modify && !second_reg)
                begin
                    second_next = 1'b1;
                    state_next = salc_pkg::ST_READ;
                end
                else
                    state_next = salc_pkg::ST_IDLE;
            end
            default:
                state_next = salc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        busy = 1'b1;
        unique case (state_reg)
            salc_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                ctl.load = start;
            end
            salc_pkg::ST_READ:
                ctl.read = 1'b1;
            salc_pkg::ST_UPDATE:
            begin
                ctl.update = 1'b1;
                ctl.last = !sts.modify || second_reg;
            end
            default:
                busy = 1'b0;
        endcase
    end
endmodule
`default_nettype wire

// ===== hw/rtl/salc_dp.sv =====
// Tag store, LRU order store, lookup and counters
`timescale 1ns / 1ps
`default_nettype none
module salc_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire salc_pkg::ctl_t                ctl,
    output salc_pkg::sts_t                     sts,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [5:0]                    cfg_data,
    input  wire logic [1:0]                    cmd,
    input  wire logic [salc_pkg::ADDR_WIDTH-1:0] address,
    output logic                               strobe,
    output logic                               hit,
    output logic                               miss,
    output logic                               evict,
    output logic                               last,
    output logic [31:0]                        hit_count,
    output logic [31:0]                        miss_count,
    output logic [31:0]                        evict_count
);
    localparam int W = salc_pkg::MAX_WAYS;
    localparam int WW = salc_pkg::WAY_W;
    localparam int FW = salc_pkg::FILL_W;
    localparam int SW = salc_pkg::SET_W;
    localparam int TW = salc_pkg::TAG_W;

    typedef logic [W-1:0][TW-1:0] tag_row_t;
    typedef logic [W-1:0][WW-1:0] ord_row_t;

    logic [2:0] set_bits_reg;
    logic [5:0] block_bits_reg;
    logic [3:0] ways_reg;
    logic modify_reg;
    logic [TW-1:0] tag_reg;
    logic [SW-1:0] set_reg;

    tag_row_t tag_mem [salc_pkg::NUM_SETS];
    ord_row_t ord_mem [salc_pkg::NUM_SETS];
    logic [FW-1:0] fill_mem [salc_pkg::NUM_SETS];
    tag_row_t tag_row_reg;
    ord_row_t ord_row_reg;
    logic [FW-1:0] fill_row_reg;
    logic [salc_pkg::NUM_SETS-1:0] used_reg;

    logic [31:0] hit_tot_reg, miss_tot_reg, evict_tot_reg;

    assign sts.modify = modify_reg;
    assign sts.skip = (cmd == salc_pkg::CMD_IFETCH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg <= 3'd1;
            block_bits_reg <= 6'd5;
            ways_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                salc_pkg::REG_SET_BITS: set_bits_reg <= cfg_data[2:0];
                salc_pkg::REG_BLOCK_BITS: block_bits_reg <= cfg_data;
                salc_pkg::REG_WAYS: ways_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    logic [2:0] s_eff;
    logic [5:0] b_eff;
    logic [3:0] e_eff;
    logic [6:0] sb;
    logic [TW-1:0] tag_calc;
    logic [TW-1:0] set_wide;
    logic [SW-1:0] set_mask;

    always_comb
    begin
        s_eff = (set_bits_reg == 3'd0) ? 3'd1 :
                (set_bits_reg > 3'(SW)) ? 3'(SW) : set_bits_reg;
        b_eff = (block_bits_reg == 6'd0) ? 6'd1 : block_bits_reg;
        e_eff = (ways_reg == 4'd0) ? 4'd1 : (ways_reg > 4'(W)) ? 4'(W) : ways_reg;
        sb = 7'(s_eff) + 7'(b_eff);
        tag_calc = (sb >= 7'(TW)) ? '0 : (address >> sb);
        set_wide = address >> b_eff;
        set_mask = SW'((1 << s_eff) - 1);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            tag_reg <= tag_calc;
            set_reg <= set_wide[SW-1:0] & set_mask;
            modify_reg <= (cmd == salc_pkg::CMD_MODIFY);
        end
    end

    logic [3:0] ways_use_reg;
    always_ff @(posedge clk)
    begin
        if (ctl.load)
            ways_use_reg <= e_eff;
    end

    // read stage: fetch the set's rows; an untouched set has no lines
    always_ff @(posedge clk)
    begin
        if (ctl.read)
        begin
            tag_row_reg <= tag_mem[set_reg];
            ord_row_reg <= ord_mem[set_reg];
            fill_row_reg <= used_reg[set_reg] ? fill_mem[set_reg] : '0;
        end
    end

    // update stage: lookup, victim choice, order rotation
    // lines fill lowest way first, so the valid ways are those below the fill count
    logic [W-1:0] vrow;
    logic [FW-1:0] fill;
    logic hit_c, found_inv, evict_c;
    logic [WW-1:0] hit_way, inv_way, way;
    logic [WW-1:0] ord_new [W];
    logic [FW-1:0] fill_new;
    logic in_list;
    logic [FW-1:0] pos;

    always_comb
    begin
        fill = fill_row_reg;
        for (int w = 0; w < W; w++)
            vrow[w] = (FW'(w) < fill);
        hit_c = 1'b0;
        hit_way = '0;
        found_inv = 1'b0;
        inv_way = '0;
        for (int w = W - 1; w >= 0; w--)
        begin
            if (4'(w) < ways_use_reg && vrow[w] && tag_row_reg[w] == tag_reg)
            begin
                hit_c = 1'b1;
                hit_way = WW'(w);
            end
            if (4'(w) < ways_use_reg && !vrow[w])
            begin
                found_inv = 1'b1;
                inv_way = WW'(w);
            end
        end
        evict_c = !hit_c && !found_inv;
        if (hit_c)
            way = hit_way;
        else if (found_inv)
            way = inv_way;
        else
            way = (fill != '0) ? ord_row_reg[0] : '0;
        in_list = 1'b0;
        pos = '0;
        for (int i = W - 1; i >= 0; i--)
        begin
            if (FW'(i) < fill && ord_row_reg[i] == way)
            begin
                in_list = 1'b1;
                pos = FW'(i);
            end
        end
        fill_new = fill;
        for (int i = 0; i < W; i++)
            ord_new[i] = ord_row_reg[i];
        if (in_list)
        begin
            for (int i = 0; i < W - 1; i++)
                if (FW'(i) >= pos && FW'(i + 1) < fill)
                    ord_new[i] = ord_row_reg[i + 1];
            for (int i = 0; i < W; i++)
                if (FW'(i + 1) == fill)
                    ord_new[i] = way;
        end
        else if (fill < FW'(W))
        begin
            for (int i = 0; i < W; i++)
                if (FW'(i) == fill)
                    ord_new[i] = way;
            fill_new = fill + 1'b1;
        end
        else
        begin
            for (int i = 0; i < W - 1; i++)
                ord_new[i] = ord_row_reg[i + 1];
            ord_new[W-1] = way;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.update)
        begin
            for (int i = 0; i < W; i++)
                ord_mem[set_reg][i] <= ord_new[i];
            fill_mem[set_reg] <= fill_new;
            if (!hit_c)
                tag_mem[set_reg][way] <= tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            hit_tot_reg <= '0;
            miss_tot_reg <= '0;
            evict_tot_reg <= '0;
            strobe <= 1'b0;
        end
        else
        begin
            strobe <= ctl.update;
            if (ctl.update)
            begin
                used_reg[set_reg] <= 1'b1;
                if (hit_c && hit_tot_reg != '1)
                    hit_tot_reg <= hit_tot_reg + 1'b1;
                if (!hit_c && miss_tot_reg != '1)
                    miss_tot_reg <= miss_tot_reg + 1'b1;
                if (evict_c && evict_tot_reg != '1)
                    evict_tot_reg <= evict_tot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.update)
        begin
            hit <= hit_c;
            miss <= !hit_c;
            evict <= evict_c;
            last <= ctl.last;
        end
    end

    assign hit_count = hit_tot_reg;
    assign miss_count = miss_tot_reg;
    assign evict_count = evict_tot_reg;
endmodule
`default_nettype wire

// ===== bench/tb_set_assoc_lru_cache_tags_core.sv =====
// Self-checking testbench for the set-associative LRU cache tag core
`timescale 1ns / 1ps
module tb_set_assoc_lru_cache_tags_core;
    localparam logic [1:0] REG_NONE = 2'd3;

    typedef struct {
        logic        hit;
        logic        miss;
        logic        evict;
        logic        last;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evicts;
    } access_t;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] addr;
        bit          typed;
        logic        t_hit;
        logic        t_evict;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  cmd = salc_pkg::CMD_LOAD;
    logic [63:0] address = 64'd0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = salc_pkg::REG_SET_BITS;
    logic [5:0]  cfg_data = 6'd0;
    logic        busy, strobe, hit, miss, evict, last;
    logic [31:0] hit_count, miss_count, evict_count;

    set_assoc_lru_cache_tags_core uut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    logic [2:0]  m_set_bits;
    logic [5:0]  m_block_bits;
    logic [3:0]  m_ways;
    bit          m_valid [salc_pkg::NUM_SETS][salc_pkg::MAX_WAYS];
    logic [63:0] m_tag [salc_pkg::NUM_SETS][salc_pkg::MAX_WAYS];
    logic [2:0]  m_order [salc_pkg::NUM_SETS][salc_pkg::MAX_WAYS];
    int          m_fill [salc_pkg::NUM_SETS];
    logic [31:0] m_hits, m_misses, m_evicts;

    access_t     pending_q[$];
    int          accepted = 0;
    int          results = 0;
    int          errors = 0;
    int          idle_pct = 0;
    int          quiet = 0;
    int          n_hit = 0, n_evict = 0, n_cfg = 0;
    bit          typed_pending = 1'b0;
    row_t        cur_row;

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void make_mru(int s, int w);
        int f;
        f = m_fill[s];
        for (int i = 0; i < f; i++)
        begin
            if (int'(m_order[s][i]) == w)
            begin
                for (int j = i; j + 1 < f; j++)
                    m_order[s][j] = m_order[s][j + 1];
                m_order[s][f - 1] = 3'(w);
                return;
            end
        end
        if (f < salc_pkg::MAX_WAYS)
        begin
            m_order[s][f] = 3'(w);
            m_fill[s] = f + 1;
        end
        else
        begin
            for (int j = 0; j + 1 < salc_pkg::MAX_WAYS; j++)
                m_order[s][j] = m_order[s][j + 1];
            m_order[s][salc_pkg::MAX_WAYS - 1] = 3'(w);
        end
    endfunction

    function automatic access_t lookup(logic [63:0] a, logic fin);
        access_t r;
        int sb, bb, nw, s, victim;
        logic [63:0] tg;
        sb = (m_set_bits == 3'd0) ? 1 :
             ((int'(m_set_bits) > salc_pkg::MAX_SET_BITS) ? salc_pkg::MAX_SET_BITS :
              int'(m_set_bits));
        bb = (m_block_bits == 6'd0) ? 1 : int'(m_block_bits);
        nw = (m_ways == 4'd0) ? 1 :
             ((int'(m_ways) > salc_pkg::MAX_WAYS) ? salc_pkg::MAX_WAYS : int'(m_ways));
        tg = (sb + bb >= 64) ? 64'd0 : (a >> (sb + bb));
        s = int'((bb >= 64 ? 64'd0 : (a >> bb)) & ((64'd1 << sb) - 64'd1));
        r.hit = 1'b0;
        r.evict = 1'b0;
        for (int w = 0; w < nw; w++)
        begin
            if (m_valid[s][w] && m_tag[s][w] == tg)
            begin
                r.hit = 1'b1;
                m_hits = sat_inc(m_hits);
                make_mru(s, w);
                break;
            end
        end
        if (!r.hit)
        begin
            victim = salc_pkg::MAX_WAYS;
            m_misses = sat_inc(m_misses);
            for (int w = 0; w < nw; w++)
            begin
                if (!m_valid[s][w])
                begin
                    victim = w;
                    break;
                end
            end
            if (victim == salc_pkg::MAX_WAYS)
            begin
                r.evict = 1'b1;
                m_evicts = sat_inc(m_evicts);
                victim = (m_fill[s] > 0) ? int'(m_order[s][0]) : 0;
            end
            m_valid[s][victim] = 1'b1;
            m_tag[s][victim] = tg;
            make_mru(s, victim);
        end
        r.miss = !r.hit;
        r.last = fin;
        r.hits = m_hits;
        r.misses = m_misses;
        r.evicts = m_evicts;
        return r;
    endfunction

    always @(posedge clk)
    begin
        access_t r, e;
        bit act;
        act = 1'b0;
        if (!rst_n)
        begin
            m_set_bits = 3'd1;
            m_block_bits = 6'd5;
            m_ways = 4'd1;
            m_hits = '0;
            m_misses = '0;
            m_evicts = '0;
            for (int s = 0; s < salc_pkg::NUM_SETS; s++)
            begin
                m_fill[s] = 0;
                for (int w = 0; w < salc_pkg::MAX_WAYS; w++)
                    m_valid[s][w] = 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                act = 1'b1;
                n_cfg++;
                case (cfg_index)
                    salc_pkg::REG_SET_BITS:   m_set_bits = cfg_data[2:0];
                    salc_pkg::REG_BLOCK_BITS: m_block_bits = cfg_data;
                    salc_pkg::REG_WAYS:       m_ways = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                act = 1'b1;
                accepted++;
                if (cmd != salc_pkg::CMD_IFETCH)
                begin
                    if (cmd == salc_pkg::CMD_MODIFY)
                        pending_q.push_back(lookup(address, 1'b0));
                    r = lookup(address, 1'b1);
                    pending_q.push_back(r);
                    if (typed_pending && cmd != salc_pkg::CMD_MODIFY &&
                        (r.hit !== cur_row.t_hit || r.evict !== cur_row.t_evict))
                    begin
                        errors++;
                        $display("%0t table row mismatch: expected hit %0b evict %0b, got %0b %0b",
                                 $time, cur_row.t_hit, cur_row.t_evict, r.hit, r.evict);
                    end
                end
            end
            if (strobe)
            begin
                act = 1'b1;
                results++;
                if (pending_q.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected result: hit %0b miss %0b evict %0b last %0b",
                             $time, hit, miss, evict, last);
                end
                else
                begin
                    e = pending_q.pop_front();
                    n_hit += int'(e.hit);
                    n_evict += int'(e.evict);
                    if (hit !== e.hit || miss !== e.miss || evict !== e.evict ||
                        last !== e.last || hit_count !== e.hits ||
                        miss_count !== e.misses || evict_count !== e.evicts)
                    begin
                        errors++;
                        $display("%0t mismatch: expected h%0b m%0b e%0b l%0b %0d/%0d/%0d",
                                 $time, e.hit, e.miss, e.evict, e.last,
                                 e.hits, e.misses, e.evicts);
                        $display("%0t          actual h%0b m%0b e%0b l%0b %0d/%0d/%0d",
                                 $time, hit, miss, evict, last,
                                 hit_count, miss_count, evict_count);
                    end
                end
            end
        end
        if (act)
            quiet <= 0;
        else if (quiet < 1000000)
            quiet <= quiet + 1;
    end

    always @(posedge clk)
    begin
        if (quiet >= 5000)
        begin
            $display("watchdog expired, %0d results outstanding", pending_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send(logic [1:0] op, logic [63:0] a);
        int n;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd <= op;
        address <= a;
        n = accepted;
        do
            @(negedge clk);
        while (accepted == n);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [5:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    row_t table_rows[] = '{
        '{salc_pkg::CMD_LOAD,   64'h0,                  1, 0, 0},
        '{salc_pkg::CMD_LOAD,   64'h1F,                 1, 1, 0},
        '{salc_pkg::CMD_STORE,  64'h20,                 1, 0, 0},
        '{salc_pkg::CMD_LOAD,   64'h40,                 1, 0, 1},
        '{salc_pkg::CMD_MODIFY, 64'h40,                 0, 0, 0},
        '{salc_pkg::CMD_IFETCH, 64'h0,                  0, 0, 0},
        '{salc_pkg::CMD_MODIFY, 64'h1000,               0, 0, 0},
        '{salc_pkg::CMD_LOAD,   64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0},
        '{salc_pkg::CMD_STORE,  64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 0},
        '{salc_pkg::CMD_STORE,  64'h8000_0000_0000_0000, 0, 0, 0},
        '{salc_pkg::CMD_IFETCH, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0},
        '{salc_pkg::CMD_MODIFY, 64'h5555_5555_5555_5555, 0, 0, 0},
        '{salc_pkg::CMD_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 0},
        '{salc_pkg::CMD_LOAD,   64'h5555_5555_5555_5555, 0, 0, 0}
    };

    logic [5:0] cfg_plan [8][3] = '{
        '{6'd0, 6'd0,  6'd0},
        '{6'd7, 6'd63, 6'd15},
        '{6'd6, 6'd1,  6'd8},
        '{6'd3, 6'd4,  6'd4},
        '{6'd1, 6'd56, 6'd2},
        '{6'd2, 6'd6,  6'd8},
        '{6'd6, 6'd58, 6'd3},
        '{6'd4, 6'd5,  6'd5}
    };
    int idle_plan[4] = '{0, 84, 0, 38};

    initial
    begin
        logic [63:0] pool[16];
        logic [63:0] a;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (table_rows[i])
        begin
            cur_row = table_rows[i];
            typed_pending = table_rows[i].typed;
            send(table_rows[i].op, table_rows[i].addr);
            typed_pending = 1'b0;
        end
        drain();
        write_reg(REG_NONE, 6'h3F);
        for (int p = 0; p < 8; p++)
        begin
            write_reg(salc_pkg::REG_SET_BITS, cfg_plan[p][0]);
            write_reg(salc_pkg::REG_BLOCK_BITS, cfg_plan[p][1]);
            write_reg(salc_pkg::REG_WAYS, cfg_plan[p][2]);
            idle_pct = idle_plan[p % 4];
            foreach (pool[i])
                pool[i] = {$urandom, $urandom};
            for (int k = 0; k < 55; k++)
            begin
                if ($urandom_range(9) < 8)
                    a = pool[$urandom_range(15)] ^ (64'(1) << $urandom_range(63));
                else
                    a = {$urandom, $urandom};
                if ($urandom_range(3) == 0)
                    a = pool[$urandom_range(15)];
                send(2'($urandom_range(3)), a);
                if (p == 3 && k == 20)
                    drain();
            end
            drain();
        end
        $display("covered %0d items, %0d results (%0d hits, %0d evictions), %0d register writes",
                 accepted, results, n_hit, n_evict, n_cfg);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
